### design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and initial values for the sha-384/512 unit
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int ROUNDS      = 80;

    localparam logic [63:0] PAD_WORD = 64'h80 << 56;
    localparam logic [3:0]  LEN_POS  = 4'd14;
    localparam logic [3:0]  MAX_BYTES = 4'd8;

    // one word handed from front to back
    typedef struct packed {
        logic [63:0] word;
        logic        open;   // first word of a message: load the initial value
        logic        fin;    // last word of the padded message
        logic        m384;   // mode at the time the word was accepted
    } sha_entry_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] iv_word(input logic m384, input logic [2:0] idx);
        logic [63:0] r;
        r = '0;
        if (m384) begin
            case (idx)
                3'd0: r = 64'hCBBB9D5DC1059ED8;
                3'd1: r = 64'h629A292A367CD507;
                3'd2: r = 64'h9159015A3070DD17;
                3'd3: r = 64'h152FECD8F70E5939;
                3'd4: r = 64'h67332667FFC00B31;
                3'd5: r = 64'h8EB44A8768581511;
                3'd6: r = 64'hDB0C2E0D64F98FA7;
                default: r = 64'h47B5481DBEFA4FA4;
            endcase
        end
        else begin
            case (idx)
                3'd0: r = 64'h6A09E667F3BCC908;
                3'd1: r = 64'hBB67AE8584CAA73B;
                3'd2: r = 64'h3C6EF372FE94F82B;
                3'd3: r = 64'hA54FF53A5F1D36F1;
                3'd4: r = 64'h510E527FADE682D1;
                3'd5: r = 64'h9B05688C2B3E6C1F;
                3'd6: r = 64'h1F83D9ABFB41BD6B;
                default: r = 64'h5BE0CD19137E2179;
            endcase
        end
        return r;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] idx);
        logic [63:0] r;
        r = '0;
        case (idx)
            7'd0:  r = 64'h428A2F98D728AE22;  7'd1:  r = 64'h7137449123EF65CD;
            7'd2:  r = 64'hB5C0FBCFEC4D3B2F;  7'd3:  r = 64'hE9B5DBA58189DBBC;
            7'd4:  r = 64'h3956C25BF348B538;  7'd5:  r = 64'h59F111F1B605D019;
            7'd6:  r = 64'h923F82A4AF194F9B;  7'd7:  r = 64'hAB1C5ED5DA6D8118;
            7'd8:  r = 64'hD807AA98A3030242;  7'd9:  r = 64'h12835B0145706FBE;
            7'd10: r = 64'h243185BE4EE4B28C;  7'd11: r = 64'h550C7DC3D5FFB4E2;
            7'd12: r = 64'h72BE5D74F27B896F;  7'd13: r = 64'h80DEB1FE3B1696B1;
            7'd14: r = 64'h9BDC06A725C71235;  7'd15: r = 64'hC19BF174CF692694;
            7'd16: r = 64'hE49B69C19EF14AD2;  7'd17: r = 64'hEFBE4786384F25E3;
            7'd18: r = 64'h0FC19DC68B8CD5B5;  7'd19: r = 64'h240CA1CC77AC9C65;
            7'd20: r = 64'h2DE92C6F592B0275;  7'd21: r = 64'h4A7484AA6EA6E483;
            7'd22: r = 64'h5CB0A9DCBD41FBD4;  7'd23: r = 64'h76F988DA831153B5;
            7'd24: r = 64'h983E5152EE66DFAB;  7'd25: r = 64'hA831C66D2DB43210;
            7'd26: r = 64'hB00327C898FB213F;  7'd27: r = 64'hBF597FC7BEEF0EE4;
            7'd28: r = 64'hC6E00BF33DA88FC2;  7'd29: r = 64'hD5A79147930AA725;
            7'd30: r = 64'h06CA6351E003826F;  7'd31: r = 64'h142929670A0E6E70;
            7'd32: r = 64'h27B70A8546D22FFC;  7'd33: r = 64'h2E1B21385C26C926;
            7'd34: r = 64'h4D2C6DFC5AC42AED;  7'd35: r = 64'h53380D139D95B3DF;
            7'd36: r = 64'h650A73548BAF63DE;  7'd37: r = 64'h766A0ABB3C77B2A8;
            7'd38: r = 64'h81C2C92E47EDAEE6;  7'd39: r = 64'h92722C851482353B;
            7'd40: r = 64'hA2BFE8A14CF10364;  7'd41: r = 64'hA81A664BBC423001;
            7'd42: r = 64'hC24B8B70D0F89791;  7'd43: r = 64'hC76C51A30654BE30;
            7'd44: r = 64'hD192E819D6EF5218;  7'd45: r = 64'hD69906245565A910;
            7'd46: r = 64'hF40E35855771202A;  7'd47: r = 64'h106AA07032BBD1B8;
            7'd48: r = 64'h19A4C116B8D2D0C8;  7'd49: r = 64'h1E376C085141AB53;
            7'd50: r = 64'h2748774CDF8EEB99;  7'd51: r = 64'h34B0BCB5E19B48A8;
            7'd52: r = 64'h391C0CB3C5C95A63;  7'd53: r = 64'h4ED8AA4AE3418ACB;
            7'd54: r = 64'h5B9CCA4F7763E373;  7'd55: r = 64'h682E6FF3D6B2B8A3;
            7'd56: r = 64'h748F82EE5DEFB2FC;  7'd57: r = 64'h78A5636F43172F60;
            7'd58: r = 64'h84C87814A1F0AB72;  7'd59: r = 64'h8CC702081A6439EC;
            7'd60: r = 64'h90BEFFFA23631E28;  7'd61: r = 64'hA4506CEBDE82BDE9;
            7'd62: r = 64'hBEF9A3F7B2C67915;  7'd63: r = 64'hC67178F2E372532B;
            7'd64: r = 64'hCA273ECEEA26619C;  7'd65: r = 64'hD186B8C721C0C207;
            7'd66: r = 64'hEADA7DD6CDE0EB1E;  7'd67: r = 64'hF57D4F7FEE6ED178;
            7'd68: r = 64'h06F067AA72176FBA;  7'd69: r = 64'h0A637DC5A2C898A6;
            7'd70: r = 64'h113F9804BEF90DAE;  7'd71: r = 64'h1B710B35131C471B;
            7'd72: r = 64'h28DB77F523047D84;  7'd73: r = 64'h32CAAB7B40C72493;
            7'd74: r = 64'h3C9EBE0A15C9BEBC;  7'd75: r = 64'h431D67C49C100D4C;
            7'd76: r = 64'h4CC5D4BECB3E42B6;  7'd77: r = 64'h597F299CFC657E2A;
            7'd78: r = 64'h5FCB6FAB3AD6FAEC;  7'd79: r = 64'h6C44198C4A475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### design/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// accepts message words, counts bytes and expands the last word into padding
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode_384,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        push,
    output sha_entry_t  push_entry,
    input  logic        queue_full
);

    typedef enum logic [2:0] {
        S_IDLE, S_DATA, S_PAD80, S_ZERO, S_LENHI, S_LENLO
    } state_t;

    state_t      state_reg;
    logic        open_reg;
    logic        first_reg;
    logic        last_reg;
    logic        full8_reg;
    logic        mode_reg;
    logic [3:0]  pos_reg;
    logic [63:0] bytes_reg;
    logic [63:0] data_reg;

    logic        accept;
    logic [3:0]  count;
    logic [63:0] fmt_word;
    logic [3:0]  pos_next;
    state_t      after_pad;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign count    = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
    assign pos_next = pos_reg + 4'd1;
    assign after_pad = (pos_next == LEN_POS) ? S_LENHI : S_ZERO;

    // keep valid bytes, put the pad marker right after them
    always_comb
    begin
        fmt_word = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < count)
                fmt_word[63 - 8*i -: 8] = data_word[63 - 8*i -: 8];
            else if (4'(i) == count)
                fmt_word[63 - 8*i -: 8] = 8'h80;
        end
    end

    always_comb
    begin
        push_entry.word = '0;
        push_entry.open = first_reg;
        push_entry.fin  = 1'b0;
        push_entry.m384 = mode_reg;
        case (state_reg)
            S_DATA:  push_entry.word = data_reg;
            S_PAD80: push_entry.word = PAD_WORD;
            S_LENHI: push_entry.word = {61'd0, bytes_reg[63:61]};
            S_LENLO:
            begin
                push_entry.word = {bytes_reg[60:0], 3'd0};
                push_entry.fin  = 1'b1;
            end
            default: push_entry.word = '0;
        endcase
    end

    assign push = (state_reg != S_IDLE) && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            open_reg  <= 1'b0;
            first_reg <= 1'b0;
            last_reg  <= 1'b0;
            full8_reg <= 1'b0;
            mode_reg  <= 1'b0;
            pos_reg   <= '0;
            bytes_reg <= '0;
            data_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg <= S_DATA;
            open_reg  <= 1'b1;
            mode_reg  <= mode_384;
            last_reg  <= last_word;
            full8_reg <= (count == MAX_BYTES);
            if (!open_reg)
            begin
                first_reg <= 1'b1;
                pos_reg   <= '0;
            end
            if (last_word)
            begin
                bytes_reg <= (open_reg ? bytes_reg : 64'd0) + 64'(count);
                data_reg  <= (count == MAX_BYTES) ? data_word : fmt_word;
            end
            else
            begin
                bytes_reg <= (open_reg ? bytes_reg : 64'd0) + 64'd8;
                data_reg  <= data_word;
            end
        end
        else if (push)
        begin
            pos_reg   <= pos_next;
            first_reg <= 1'b0;
            unique case (state_reg)
                S_DATA:
                begin
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (full8_reg)
                        state_reg <= S_PAD80;
                    else
                        state_reg <= after_pad;
                end
                S_PAD80: state_reg <= after_pad;
                S_ZERO:  state_reg <= after_pad;
                S_LENHI: state_reg <= S_LENLO;
                S_LENLO:
                begin
                    state_reg <= S_IDLE;
                    open_reg  <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### design/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// short fifo of padded words between front and back
// ----------------------------------------------------------------------------
module sha_queue
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sha_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output sha_entry_t pop_entry
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    sha_entry_t    mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_entry = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### design/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// block buffer, message schedule, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  sha_entry_t  pop_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        digest_last
);

    typedef enum logic [1:0] { C_FILL, C_ROUND, C_ADD, C_OUT } state_t;

    state_t      state_reg;
    logic [63:0] chain_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] win_reg [16];
    logic [3:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic        fin_reg;
    logic        m384_reg;

    logic [63:0] s0, s1, w_new, t1, t2, ch, maj;
    logic [2:0]  last_idx;

    assign pop = (state_reg == C_FILL) && not_empty;

    // schedule: w[t+16] from the sliding window
    assign s0 = rotr(win_reg[1], 1) ^ rotr(win_reg[1], 8) ^ (win_reg[1] >> 7);
    assign s1 = rotr(win_reg[14], 19) ^ rotr(win_reg[14], 61) ^ (win_reg[14] >> 6);
    assign w_new = s1 + win_reg[9] + s0 + win_reg[0];

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
                 + ch + round_k(rnd_reg) + win_reg[0];
    assign t2  = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39)) + maj;

    assign last_idx    = m384_reg ? 3'd5 : 3'd7;
    assign out_valid   = (state_reg == C_OUT);
    assign digest_word = chain_reg[oidx_reg];
    assign digest_last = (oidx_reg == last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_FILL;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            fin_reg   <= 1'b0;
            m384_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= iv_word(1'b0, 3'(i));
                v_reg[i]     <= '0;
            end
            for (int i = 0; i < 16; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_FILL:
                begin
                    if (pop)
                    begin
                        for (int i = 0; i < 15; i++)
                            win_reg[i] <= win_reg[i+1];
                        win_reg[15] <= pop_entry.word;
                        pos_reg     <= pos_reg + 4'd1;
                        if (pop_entry.open)
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= iv_word(pop_entry.m384, 3'(i));
                        if (pos_reg == 4'd15)
                        begin
                            fin_reg   <= pop_entry.fin;
                            m384_reg  <= pop_entry.m384;
                            rnd_reg   <= '0;
                            state_reg <= C_ROUND;
                            for (int i = 0; i < 8; i++)
                                v_reg[i] <= chain_reg[i];
                        end
                    end
                end
                C_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        win_reg[i] <= win_reg[i+1];
                    win_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'(ROUNDS - 1))
                        state_reg <= C_ADD;
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    oidx_reg  <= '0;
                    state_reg <= fin_reg ? C_OUT : C_FILL;
                end
                C_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == last_idx)
                            state_reg <= C_FILL;
                    end
                end
                default: state_reg <= C_FILL;
            endcase
        end
    end

    // no words are taken in while a digest is being delivered
    a_no_pop_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pop)
        else $error("word popped during digest output");

    // compression always starts from a full block
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND && rnd_reg == 7'd0) |-> $past(pop) && $past(pos_reg) == 4'd15)
        else $error("compression started on a partial block");

    // no digest word follows the accepted transfer that carries digest_last
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && digest_last && !out_stall) |=> !out_valid)
        else $error("digest continued past its last word");

endmodule

### design/sha384_sha512_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha384_sha512_hasher_unit
// sha-384 / sha-512 hash engine with padding and digest readout
// ----------------------------------------------------------------------------
// Message words enter big-endian (first byte in bits 63:56) with a byte count
// and a last flag; only the last word may be partial. The front stage stalls
// the input until each accepted word (and after the last word, its padding)
// is pushed into the queue. It counts message bytes and, on the last word,
// generates the 0x80 marker, zero fill and 128-bit bit length (in the last
// block or spilling into one more). Words go through a four-entry queue to
// the back stage, which shifts 16 words into the schedule window and runs one
// round per clock. While a block compresses the queue fills up, so the next
// block takes its first words from the queue and the rest at the pace of the
// front; the sustained rate is set by the single round unit and the front.
// After the final block the digest leaves as 8 words (SHA-512) or 6 words
// (SHA-384, mode register bit set), most significant first, with digest_last
// on the final one; the next message starts from the initial value of the
// mode in effect when its first word is accepted. Mode lives at APB address 0.
// ----------------------------------------------------------------------------
module sha384_sha512_hasher_unit
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // message input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    // digest output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        digest_last
);

    localparam logic [2:0] ADDR_MODE = 3'd0;

    logic       mode_reg;
    logic       q_push, q_full, q_pop, q_not_empty;
    sha_entry_t q_in, q_out;

    // register file: only the mode bit
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == ADDR_MODE)
            mode_reg <= pwdata[0];
    end

    // front: accept transfers, pad and count
    sha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_384   (mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .valid_bytes(valid_bytes),
        .last_word  (last_word),
        .push       (q_push),
        .push_entry (q_in),
        .queue_full (q_full)
    );

    // queue decouples padding from compression
    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_entry (q_out)
    );

    // back: schedule, rounds, digest transfers
    sha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (q_not_empty),
        .pop_entry  (q_out),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_word(digest_word),
        .digest_last(digest_last)
    );

endmodule

### bench/tb_sha384_sha512_hasher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha384_sha512_hasher_unit
// self-checking bench for the sha-384/512 hash engine
// ----------------------------------------------------------------------------
// Messages are fed as 64-bit words with random idle bursts on both channels.
// A behavioral hash model in the bench computes each digest on the last word
// and the monitor compares every digest transfer in order. The mode register
// is changed between phases while the engine is idle, and once mid-message.
// ----------------------------------------------------------------------------
module tb_sha384_sha512_hasher_unit;
    import sha_pkg::*;

    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        fin;
    } msg_word_t;

    typedef struct packed {
        logic [63:0] word;
        logic        fin;
    } digest_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic        digest_last;

    sha384_sha512_hasher_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .digest_last (digest_last)
    );

    // ------------------------------------------------------------------
    // hash model state
    // ------------------------------------------------------------------
    logic [63:0] k_tab [0:79];
    logic [63:0] hv [0:7];
    logic [63:0] blk [0:15];
    logic [3:0]  wpos;
    logic [63:0] byte_cnt;
    logic        msg_busy;
    logic        mode_sel;

    msg_word_t pending_words[$];
    digest_t   expected_digests[$];
    int        mismatches;
    int        matched;
    bit        stim_done;
    bit        no_idle;
    bit        hold_input;
    int        in_gap;
    int        out_gap;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_value(input logic m384, input int i);
        logic [63:0] v512 [0:7];
        logic [63:0] v384 [0:7];
        v512 = '{64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
                 64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
                 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
        v384 = '{64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
                 64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
                 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};
        return m384 ? v384[i] : v512[i];
    endfunction

    task automatic load_init();
        for (int i = 0; i < 8; i++)
            hv[i] = init_value(mode_sel, i);
    endtask

    task automatic compress_block();
        logic [63:0] w [0:79];
        logic [63:0] v [0:7];
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] ch;
        logic [63:0] mj;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                 + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int i = 0; i < 80; i++)
        begin
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41)) + ch
               + k_tab[i] + w[i];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39)) + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hv[i] += v[i];
    endtask

    task automatic append_word(input logic [63:0] w);
        blk[wpos] = w;
        wpos = wpos + 4'd1;
        if (wpos == 4'd0)
            compress_block();
    endtask

    // model one accepted message word, queue digest words on the last one
    task automatic hash_word(input msg_word_t it);
        int cnt;
        int n;
        logic [63:0] w;
        digest_t d;
        if (!msg_busy)
        begin
            load_init();
            wpos = '0;
            byte_cnt = '0;
            msg_busy = 1'b1;
        end
        if (!it.fin)
        begin
            byte_cnt += 64'd8;
            append_word(it.data);
            return;
        end
        cnt = (it.nbytes > 4'd8) ? 8 : int'(it.nbytes);
        byte_cnt += 64'(cnt);
        if (cnt == 8)
        begin
            append_word(it.data);
            append_word(PAD_WORD);
        end
        else
        begin
            w = (cnt == 0) ? 64'd0 : (it.data & ({64{1'b1}} << (64 - 8 * cnt)));
            w |= 64'h80 << (56 - 8 * cnt);
            append_word(w);
        end
        if (wpos > 4'd14)
            append_word(64'd0);
        while (wpos != 4'd14)
            append_word(64'd0);
        append_word(byte_cnt >> 61);
        append_word(byte_cnt << 3);
        n = mode_sel ? 6 : 8;
        for (int i = 0; i < n; i++)
        begin
            d.word = hv[i];
            d.fin = (i == n - 1);
            expected_digests.push_back(d);
        end
        load_init();
        wpos = '0;
        byte_cnt = '0;
        msg_busy = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // clock and limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_sha384_sha512_hasher_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // input driver: one transfer per accepting edge, random idle bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            data_word   <= '0;
            valid_bytes <= '0;
            last_word   <= 1'b0;
            in_gap      <= 0;
        end
        else
        begin
            automatic bit done = in_valid && !in_stall;
            if (in_valid && !done)
            begin
                // stalled payload holds
            end
            else if (hold_input || pending_words.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 9);
            end
            else
            begin
                automatic msg_word_t it = pending_words.pop_front();
                in_valid    <= 1'b1;
                data_word   <= it.data;
                valid_bytes <= it.nbytes;
                last_word   <= it.fin;
            end
            if (done)
                hash_word('{data_word, valid_bytes, last_word});
        end
    end

    // ------------------------------------------------------------------
    // output monitor and stall generator
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest transfer %h last %b",
                                 digest_word, digest_last);
                end
                else
                begin
                    automatic digest_t d = expected_digests.pop_front();
                    if (d.word !== digest_word || d.fin !== digest_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%b got %h/%b",
                                     d.word, d.fin, digest_word, digest_last);
                    end
                    else
                        matched++;
                end
            end
            // random stall bursts, counted down in out_gap
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                out_gap   <= $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_word(input logic [63:0] d, input logic [3:0] nb, input logic f);
        msg_word_t it;
        it.data = d;
        it.nbytes = nb;
        it.fin = f;
        pending_words.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // message of nfull whole words and a final word of nb bytes
    task automatic add_message(input int nfull, input logic [3:0] nb);
        for (int i = 0; i < nfull; i++)
            add_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
        add_word(rand64(), nb, 1'b1);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= {31'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        mode_sel = m;
        if (!msg_busy)
            load_init();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        k_tab = '{
            64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
            64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
            64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
            64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
            64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
            64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
            64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
            64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
            64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
            64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
            64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
            64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
            64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
            64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
            64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
            64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
            64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
            64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
            64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
            64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
        mode_sel   = 1'b0;
        load_init();
        wpos       = '0;
        byte_cnt   = '0;
        msg_busy   = 1'b0;
        mismatches = 0;
        matched    = 0;
        stim_done  = 0;
        no_idle    = 0;
        hold_input = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme data, byte counts, padding spilling to a second block
        add_word(64'd0, 4'd8, 1'b1);                      // one full zero word
        add_word({64{1'b1}}, 4'd1, 1'b1);                 // one byte
        add_word({64{1'b1}}, 4'd0, 1'b1);                 // empty message
        add_word(64'h0123456789ABCDEF, 4'd15, 1'b1);      // count saturates
        add_message(13, 4'd8);                            // length spills
        add_message(14, 4'd3);
        drain();

        // hold_input drops again before any edge, so these two messages are not held
        hold_input = 1;
        add_message(15, 4'd8);
        add_message(1, 4'd0);
        hold_input = 0;
        drain();

        // sha-384 phase
        write_mode(1'b1);
        add_message(0, 4'd8);
        add_message(3, 4'd5);
        add_message(16, 4'd2);
        drain();

        // mode change mid-message: initial value kept, digest length follows mode
        add_word(rand64(), 4'd8, 1'b0);
        add_word(rand64(), 4'd8, 1'b0);
        drain();
        write_mode(1'b0);
        add_word(rand64(), 4'd7, 1'b1);
        drain();

        // random phases with both modes
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode(ph[0]);
            if (ph == 3)
                no_idle = 1;
            for (int m = 0; m < 4; m++)
                add_message($urandom_range(0, 3) == 0 ? $urandom_range(14, 20)
                                                       : $urandom_range(0, 6),
                            4'($urandom_range(0, 15)));
            drain();
        end

        if (mismatches == 0)
            $display("tb_sha384_sha512_hasher_unit: PASS");
        else
            $display("tb_sha384_sha512_hasher_unit: FAIL");
        $finish;
    end

endmodule

### files.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_queue.sv
design/sha_core.sv
design/sha384_sha512_hasher_unit.sv
bench/tb_sha384_sha512_hasher_unit.sv
